// ----- rtl/index_linked_stack_with_drain_macros.svh -----
// Assertion macros for the index-linked stack.
`ifndef INDEX_LINKED_STACK_WITH_DRAIN_MACROS_SVH
`define INDEX_LINKED_STACK_WITH_DRAIN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ils_pkg.sv -----
// Types and constants shared by the index-linked stack.
package ils_pkg;

  localparam int IDX_W       = 6;
  localparam int LINK_W      = 7;
  localparam int COUNT_W     = 7;
  localparam int STORE_DEPTH = 64;

  localparam logic [LINK_W-1:0]  NULL_LINK = 7'h7f;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_DRAIN = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_RD_WAIT,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   index;
    logic               null_flag;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

// ----- rtl/ils_req_if.sv -----
// Request channel: action and entry index.
interface ils_req_if;
  import ils_pkg::*;

  logic             valid;
  logic             ready;
  action_t          action;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, output action, output entry_index, input ready);
  modport sink   (input valid, input action, input entry_index, output ready);
endinterface

// ----- rtl/ils_rsp_if.sv -----
// Response channel: result index, null flag and entry count.
interface ils_rsp_if;
  import ils_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   result_index;
  logic               result_null;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output result_index, output result_null,
                  output entry_count, input ready);
  modport sink   (input valid, input result_index, input result_null,
                  input entry_count, output ready);
endinterface

// ----- rtl/ils_ram.sv -----
// Generic simple dual-port RAM, registered read, old data on collision.
module ils_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ils_ctrl.sv -----
// Stack sequencer: head, count, link memory and the drain walk.
module ils_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  ils_req_if.sink         req,
  input  logic            full,
  output ils_pkg::res_t   res
);
  import ils_pkg::*;

  localparam int WW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (WW > COUNT_W) ? WW : COUNT_W;
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (DEPTH < 127) ? COUNT_W'(DEPTH) : COUNT_MAX;
  localparam logic [WW-1:0] WALK_LIMIT = WW'(DEPTH);

  state_t              state, state_next;
  logic [LINK_W-1:0]   head, head_next;
  logic [COUNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]    cur, cur_next;
  logic [LINK_W-1:0]   last, last_next;
  logic [WW-1:0]       walked, walked_next;
  logic [WW-1:0]       walked_inc;

  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic [LINK_W-1:0]   wr_data, ram_rdata, link_q;
  logic                fwd_hit;
  logic [LINK_W-1:0]   fwd_data;

  logic [LINK_W-1:0]   res_link;
  logic                res_valid;
  logic                accept;
  logic [CMP_W-1:0]    count_ext, walked_ext;

  ils_ram #(.WIDTH(LINK_W), .DEPTH(STORE_DEPTH)) u_links (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // same-entry write and read in one cycle: pass the new link through
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= rd_en && wr_en && (rd_addr == wr_addr);
    end
    fwd_data <= wr_data;
  end

  assign link_q = fwd_hit ? fwd_data : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      head   <= NULL_LINK;
      count  <= '0;
      walked <= '0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      count  <= count_next;
      walked <= walked_next;
    end
    cur  <= cur_next;
    last <= last_next;
  end

  assign accept     = req.valid && req.ready;
  assign walked_inc = walked + WW'(1);
  assign count_ext  = CMP_W'(count);
  assign walked_ext = CMP_W'(walked_inc);

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    cur_next    = cur;
    last_next   = last;
    walked_next = walked;
    rd_en       = 1'b0;
    rd_addr     = cur;
    wr_en       = 1'b0;
    wr_addr     = cur;
    wr_data     = NULL_LINK;
    res_valid   = 1'b0;
    res_link    = NULL_LINK;
    req.ready   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        req.ready = !full;
        if (accept) begin
          unique case (req.action)
            ACT_PUSH: begin
              wr_en      = 1'b1;
              wr_addr    = req.entry_index;
              wr_data    = head;
              res_link   = head;
              res_valid  = 1'b1;
              head_next  = {1'b0, req.entry_index};
              count_next = (count < COUNT_CAP) ? count + COUNT_W'(1) : count;
            end
            ACT_POP: begin
              if (head == NULL_LINK) begin
                res_valid = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head[IDX_W-1:0];
                cur_next   = head[IDX_W-1:0];
                state_next = ST_POP_WAIT;
              end
            end
            ACT_DRAIN: begin
              if (head == NULL_LINK) begin
                res_valid = 1'b1;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = head[IDX_W-1:0];
                cur_next    = head[IDX_W-1:0];
                last_next   = NULL_LINK;
                walked_next = '0;
                head_next   = NULL_LINK;
                state_next  = ST_WALK;
              end
            end
            ACT_READ: begin
              rd_en      = 1'b1;
              rd_addr    = req.entry_index;
              state_next = ST_RD_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_POP_WAIT: begin
        head_next  = link_q;
        wr_en      = 1'b1;
        wr_addr    = cur;
        wr_data    = NULL_LINK;
        count_next = (count != '0) ? count - COUNT_W'(1) : '0;
        res_link   = {1'b0, cur};
        res_valid  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD_WAIT: begin
        res_link   = link_q;
        res_valid  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_WALK: begin
        // reverse one link per cycle
        wr_en     = 1'b1;
        wr_addr   = cur;
        wr_data   = last;
        last_next = {1'b0, cur};
        if (link_q != NULL_LINK && walked_inc < WALK_LIMIT) begin
          rd_en       = 1'b1;
          rd_addr     = link_q[IDX_W-1:0];
          cur_next    = link_q[IDX_W-1:0];
          walked_next = walked_inc;
        end else begin
          count_next = (count_ext > walked_ext) ?
                       COUNT_W'(count_ext - walked_ext) : '0;
          res_link   = {1'b0, cur};
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    res.valid     = res_valid;
    res.null_flag = (res_link == NULL_LINK);
    res.index     = (res_link == NULL_LINK) ? '0 : res_link[IDX_W-1:0];
    res.count     = count_next;
  end

endmodule

// ----- rtl/ils_outq.sv -----
// Two-slot result queue between the sequencer and the response channel.
module ils_outq (
  input  logic          clk,
  input  logic          rst,
  input  ils_pkg::res_t res,
  output logic          full,
  ils_rsp_if.source     rsp
);
  import ils_pkg::*;

  logic v0, v1;
  res_t slot0, slot1;
  logic pop;

  assign pop  = v0 && rsp.ready;
  assign full = v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop) begin
      if (v1) begin
        slot0 <= slot1;
        v1    <= res.valid;
        slot1 <= res;
      end else begin
        v0    <= res.valid;
        slot0 <= res;
      end
    end else if (res.valid) begin
      if (!v0) begin
        v0    <= 1'b1;
        slot0 <= res;
      end else begin
        v1    <= 1'b1;
        slot1 <= res;
      end
    end
  end

  assign rsp.valid        = v0;
  assign rsp.result_index = slot0.index;
  assign rsp.result_null  = slot0.null_flag;
  assign rsp.entry_count  = slot0.count;

endmodule

// ----- rtl/index_linked_stack_with_drain.sv -----
// Push: result queued in the cycle after accept; one item a cycle while not full.
// Pop and link read: registered link memory read, result from a wait state.
// Drain: one link reversed per cycle, at most DEPTH links.
// A result may wait in the two-slot output queue while the next item is taken.
// Reset empties the stack (head null, count zero); link memory is not cleared.
`include "index_linked_stack_with_drain_macros.svh"

module index_linked_stack_with_drain #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);
  import ils_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (DEPTH < 127) ? COUNT_W'(DEPTH) : COUNT_MAX;

  res_t res;
  logic full;

  ils_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .full (full),
    .res  (res)
  );

  ils_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .res  (res),
    .full (full),
    .rsp  (rsp)
  );

  `ILS_ASSERT_NOW(a_no_overflow, res.valid, !full, "result issued into a full queue")
  `ILS_ASSERT_NOW(a_null_index, rsp.valid && rsp.result_null, rsp.result_index == '0, "null result with nonzero index")
  `ILS_ASSERT_NOW(a_count_cap, rsp.valid, rsp.entry_count <= COUNT_CAP, "entry count above cap")
  `ILS_ASSERT_NEXT(a_read_waits, req.valid && req.ready && req.action == ACT_READ, !req.ready, "link read did not wait for memory")

endmodule
